// File: rtl/ffpa_pkg.sv
// Shared types, widths and codes for the first-fit paragraph allocator.
// Depends on nothing; every RTL file refers to it by scoped names.
`default_nettype none

package ffpa_pkg;

    // Table geometry
    localparam int EXT_DEPTH  = 16;
    localparam int EXT_AW     = 4;
    localparam int CNT_W      = 5;
    localparam int BLK_DEPTH  = 32;
    localparam int BLK_AW     = 5;
    localparam int SLOT_W     = 6;
    localparam int HDR_PARAS  = 1;
    localparam int SEG_W      = 16;
    localparam int LEN_W      = 17;
    localparam int KIND_W     = 2;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_MEM   = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OUTSIDE  = 3'd4,
        ST_OVERLAP  = 3'd5,
        ST_FULL     = 3'd6
    } status_e;

    typedef enum logic [1:0] {
        CFG_BASE   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_MAXREQ = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_idx_e;

    // Write port of the free extent table
    typedef struct packed {
        logic              en;
        logic [EXT_AW-1:0] addr;
        logic [SEG_W-1:0]  start;
        logic [LEN_W-1:0]  len;
    } ext_wr_t;

    // Write port of the block record table
    typedef struct packed {
        logic              en;
        logic [BLK_AW-1:0] addr;
        logic [SEG_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic [KIND_W-1:0] kind;
    } blk_wr_t;

    // Valid bit control of the block record table
    typedef struct packed {
        logic              clr_all;
        logic              clr_en;
        logic [BLK_AW-1:0] clr_addr;
    } blk_vld_t;

endpackage

`default_nettype wire

// File: rtl/ffpa_alu.sv
// Shared adder and comparator used by the allocator sequencer.
// Depends on ffpa_pkg for widths.
`default_nettype none

module ffpa_alu (
    input  wire logic [ffpa_pkg::LEN_W-1:0] a,
    input  wire logic [ffpa_pkg::LEN_W-1:0] b,
    input  wire logic [ffpa_pkg::LEN_W-1:0] c,
    output logic      [ffpa_pkg::LEN_W:0]   sum,
    output logic                            gt,
    output logic                            eq
);

    // Add, then compare the sum against the reference operand
    always_comb
    begin
        sum = {1'b0, a} + {1'b0, b};
        gt  = sum > {1'b0, c};
        eq  = sum == {1'b0, c};
    end

endmodule

`default_nettype wire

// File: rtl/ffpa_ext_table.sv
// Free extent table: start and length memory, one write and one registered read.
// Depends on ffpa_pkg for widths and the write port struct.
`default_nettype none

module ffpa_ext_table (
    input  wire logic                            clk,
    input  wire ffpa_pkg::ext_wr_t               wr,
    input  wire logic [ffpa_pkg::EXT_AW-1:0]     rd_addr,
    output logic      [ffpa_pkg::SEG_W-1:0]      rd_start,
    output logic      [ffpa_pkg::LEN_W-1:0]      rd_len
);

    logic [ffpa_pkg::SEG_W-1:0] start_mem [ffpa_pkg::EXT_DEPTH];
    logic [ffpa_pkg::LEN_W-1:0] len_mem   [ffpa_pkg::EXT_DEPTH];
    logic [ffpa_pkg::SEG_W-1:0] rd_start_reg;
    logic [ffpa_pkg::LEN_W-1:0] rd_len_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            start_mem[wr.addr] <= wr.start;
            len_mem[wr.addr]   <= wr.len;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
    end

    assign rd_start = rd_start_reg;
    assign rd_len   = rd_len_reg;

endmodule

`default_nettype wire

// File: rtl/ffpa_blk_table.sv
// Block record table: start, length and kind memory plus one valid flop per record.
// Depends on ffpa_pkg for widths and the port structs.
`default_nettype none

module ffpa_blk_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ffpa_pkg::blk_wr_t               wr,
    input  wire ffpa_pkg::blk_vld_t              vld_ctl,
    input  wire logic [ffpa_pkg::BLK_AW-1:0]     rd_addr,
    output logic      [ffpa_pkg::SEG_W-1:0]      rd_start,
    output logic      [ffpa_pkg::LEN_W-1:0]      rd_len,
    output logic                                 rd_valid
);

    logic [ffpa_pkg::SEG_W-1:0]  start_mem [ffpa_pkg::BLK_DEPTH];
    logic [ffpa_pkg::LEN_W-1:0]  len_mem   [ffpa_pkg::BLK_DEPTH];
    logic [ffpa_pkg::KIND_W-1:0] kind_mem  [ffpa_pkg::BLK_DEPTH];
    logic [ffpa_pkg::SEG_W-1:0]  rd_start_reg;
    logic [ffpa_pkg::LEN_W-1:0]  rd_len_reg;
    logic [ffpa_pkg::BLK_DEPTH-1:0] valid_reg;

    // Record storage with a registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            start_mem[wr.addr] <= wr.start;
            len_mem[wr.addr]   <= wr.len;
            kind_mem[wr.addr]  <= wr.kind;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
    end

    // Valid flops: set on record write, drop on free or init
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (vld_ctl.clr_all)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (vld_ctl.clr_en)
            begin
                valid_reg[vld_ctl.clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_start = rd_start_reg;
    assign rd_len   = rd_len_reg;
    assign rd_valid = valid_reg[rd_addr];

endmodule

`default_nettype wire

// File: rtl/first_fit_paragraph_allocator.sv
// Top level of the first-fit paragraph allocator: sequencer, config registers, result register.
// Depends on ffpa_pkg, ffpa_alu, ffpa_ext_table and ffpa_blk_table.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  request | in_valid/in_ready, operation, alloc_size,        | in
//          | block_type, block_segment                        |
//  result  | out_valid/out_ready, status, address             | out
//  config  | cfg_we, cfg_index, cfg_data                      | in
//
// Allocate scans E extents and B record slots and shifts S entries on an exact fit; free
// scans B records and E extents and shifts S entries, where E is the extent scan length
// (up to 16), B the record scan length (up to 32) and S the entries shifted (up to 15);
// extents and free-side records take a read and an evaluate state each (registered reads).
// One request is worked at a time.
// Reset clears the free count and record valid bits and sets the config registers to defaults.
// A finished result waits in its final state until the output register is free.
`default_nettype none

module first_fit_paragraph_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] alloc_size,
    input  wire logic [1:0]  block_type,
    input  wire logic [15:0] block_segment,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      address,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_SCAN_RD,
        S_A_SCAN_EV,
        S_A_SLOT,
        S_A_REC,
        S_A_SPLIT,
        S_DROP_RD,
        S_DROP_WR,
        S_COMMIT,
        S_F_FIND_RD,
        S_F_FIND_EV,
        S_F_POS_RD,
        S_F_POS_EV,
        S_F_CHKQ,
        S_F_CHKP,
        S_F_MERGE,
        S_F_SUM,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_FIN
    } state_t;

    localparam int SW = ffpa_pkg::SEG_W;
    localparam int LW = ffpa_pkg::LEN_W;
    localparam int CW = ffpa_pkg::CNT_W;
    localparam int AW = ffpa_pkg::EXT_AW;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [ffpa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [SW-1:0] hdr_reg, hdr_next;
    logic [LW-1:0] need_reg, need_next;
    logic [1:0]    kind_reg, kind_next;
    logic [SW-1:0] q_start_reg, q_start_next;
    logic [LW-1:0] q_len_reg, q_len_next;
    logic [SW-1:0] p_start_reg, p_start_next;
    logic [LW-1:0] p_len_reg, p_len_next;
    logic [LW-1:0] acc_reg, acc_next;
    logic has_p_reg, has_p_next;
    logic left_reg, left_next;
    logic right_reg, right_next;
    logic is_free_reg, is_free_next;
    ffpa_pkg::status_e res_status_reg, res_status_next;
    logic [SW-1:0] res_addr_reg, res_addr_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    logic [SW-1:0] address_reg, address_next;
    logic [SW-1:0] base_reg, base_next;
    logic [SW-1:0] top_reg, top_next;
    logic [SW-1:0] maxreq_reg, maxreq_next;

    ffpa_pkg::ext_wr_t  ext_wr;
    ffpa_pkg::blk_wr_t  blk_wr;
    ffpa_pkg::blk_vld_t blk_vld;
    logic [AW-1:0] ext_rd_addr;
    logic [SW-1:0] ext_rd_start;
    logic [LW-1:0] ext_rd_len;
    logic [SW-1:0] blk_rd_start;
    logic [LW-1:0] blk_rd_len;
    logic          blk_rd_valid;
    logic [LW-1:0] alu_a, alu_b, alu_c;
    logic [LW:0]   alu_sum;
    logic          alu_gt, alu_eq;
    logic [CW-1:0] ptr_m1;
    logic [LW-1:0] round_sum;
    logic [LW-1:0] paras;
    logic [LW-1:0] req_need;

    ffpa_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .sum (alu_sum),
        .gt  (alu_gt),
        .eq  (alu_eq)
    );

    ffpa_ext_table u_ext (
        .clk      (clk),
        .wr       (ext_wr),
        .rd_addr  (ext_rd_addr),
        .rd_start (ext_rd_start),
        .rd_len   (ext_rd_len)
    );

    ffpa_blk_table u_blk (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (blk_wr),
        .vld_ctl  (blk_vld),
        .rd_addr  (slot_reg[ffpa_pkg::BLK_AW-1:0]),
        .rd_start (blk_rd_start),
        .rd_len   (blk_rd_len),
        .rd_valid (blk_rd_valid)
    );

    assign ptr_m1 = ptr_reg - CW'(1);

    // Round bytes up to paragraphs and add the header
    assign round_sum = {1'b0, alloc_size} + LW'(15);
    assign paras     = round_sum >> 4;
    assign req_need  = paras + LW'(ffpa_pkg::HDR_PARAS);

    // Pick the extent read address for the current step
    always_comb
    begin
        case (state_reg)
            S_DROP_RD: ext_rd_addr = ptr_reg[AW-1:0];
            S_INS_RD:  ext_rd_addr = ptr_m1[AW-1:0];
            default:   ext_rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        hdr_next        = hdr_reg;
        need_next       = need_reg;
        kind_next       = kind_reg;
        q_start_next    = q_start_reg;
        q_len_next      = q_len_reg;
        p_start_next    = p_start_reg;
        p_len_next      = p_len_reg;
        acc_next        = acc_reg;
        has_p_next      = has_p_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        is_free_next    = is_free_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        address_next    = address_reg;
        base_next       = base_reg;
        top_next        = top_reg;
        maxreq_next     = maxreq_reg;
        ext_wr          = '0;
        blk_wr          = '0;
        blk_vld         = '0;
        alu_a           = '0;
        alu_b           = '0;
        alu_c           = '0;

        // Config writes
        if (cfg_we)
        begin
            case (cfg_index)
                ffpa_pkg::CFG_BASE:   base_next   = cfg_data;
                ffpa_pkg::CFG_TOP:    top_next    = cfg_data;
                ffpa_pkg::CFG_MAXREQ: maxreq_next = cfg_data;
                default:              ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ffpa_pkg::ST_OK;
                    res_addr_next   = '0;
                    is_free_next    = 1'b0;
                    case (operation)
                        ffpa_pkg::OP_INIT:
                        begin
                            blk_vld.clr_all = 1'b1;
                            if (top_reg >= base_reg)
                            begin
                                ext_wr.en    = 1'b1;
                                ext_wr.addr  = '0;
                                ext_wr.start = base_reg;
                                ext_wr.len   = {1'b0, top_reg} - {1'b0, base_reg} + LW'(1);
                                cnt_next     = CW'(1);
                            end
                            else
                            begin
                                cnt_next = '0;
                            end
                            state_next = S_FIN;
                        end
                        ffpa_pkg::OP_ALLOC:
                        begin
                            if (paras == '0 || req_need > {1'b0, maxreq_reg})
                            begin
                                res_status_next = ffpa_pkg::ST_BAD_SIZE;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                need_next  = req_need;
                                kind_next  = block_type;
                                idx_next   = '0;
                                state_next = S_A_SCAN_RD;
                            end
                        end
                        ffpa_pkg::OP_FREE:
                        begin
                            hdr_next     = block_segment - SW'(ffpa_pkg::HDR_PARAS);
                            is_free_next = 1'b1;
                            slot_next    = '0;
                            state_next   = S_F_FIND_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Walk extents for the first one large enough
            S_A_SCAN_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    res_status_next = ffpa_pkg::ST_NO_MEM;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_A_SCAN_EV;
                end
            end

            S_A_SCAN_EV:
            begin
                if (ext_rd_len >= need_reg)
                begin
                    q_start_next = ext_rd_start;
                    q_len_next   = ext_rd_len;
                    slot_next    = '0;
                    state_next   = S_A_SLOT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_A_SCAN_RD;
                end
            end

            // Find a free record slot
            S_A_SLOT:
            begin
                if (slot_reg == ffpa_pkg::SLOT_W'(ffpa_pkg::BLK_DEPTH))
                begin
                    res_status_next = ffpa_pkg::ST_FULL;
                    state_next      = S_FIN;
                end
                else if (blk_rd_valid)
                begin
                    slot_next = slot_reg + ffpa_pkg::SLOT_W'(1);
                end
                else
                begin
                    state_next = S_A_REC;
                end
            end

            S_A_REC:
            begin
                blk_wr.en       = 1'b1;
                blk_wr.addr     = slot_reg[ffpa_pkg::BLK_AW-1:0];
                blk_wr.start    = q_start_reg;
                blk_wr.len      = need_reg;
                blk_wr.kind     = kind_reg;
                res_status_next = ffpa_pkg::ST_OK;
                res_addr_next   = q_start_reg + SW'(ffpa_pkg::HDR_PARAS);
                if (q_len_reg == need_reg)
                begin
                    ptr_next   = idx_reg + CW'(1);
                    state_next = S_DROP_RD;
                end
                else
                begin
                    state_next = S_A_SPLIT;
                end
            end

            // Shrink the chosen extent from its low end
            S_A_SPLIT:
            begin
                alu_a        = {1'b0, q_start_reg};
                alu_b        = need_reg;
                ext_wr.en    = 1'b1;
                ext_wr.addr  = idx_reg[AW-1:0];
                ext_wr.start = alu_sum[SW-1:0];
                ext_wr.len   = q_len_reg - need_reg;
                state_next   = S_FIN;
            end

            // Close the gap left by a dropped extent
            S_DROP_RD:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    state_next = S_DROP_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_COMMIT;
                end
            end

            S_DROP_WR:
            begin
                ext_wr.en    = 1'b1;
                ext_wr.addr  = ptr_m1[AW-1:0];
                ext_wr.start = ext_rd_start;
                ext_wr.len   = ext_rd_len;
                ptr_next     = ptr_reg + CW'(1);
                state_next   = S_DROP_RD;
            end

            S_COMMIT:
            begin
                if (is_free_reg)
                begin
                    blk_vld.clr_en   = 1'b1;
                    blk_vld.clr_addr = slot_reg[ffpa_pkg::BLK_AW-1:0];
                end
                res_status_next = ffpa_pkg::ST_OK;
                state_next      = S_FIN;
            end

            // Look up the record of the block being released
            S_F_FIND_RD:
            begin
                if (slot_reg == ffpa_pkg::SLOT_W'(ffpa_pkg::BLK_DEPTH))
                begin
                    res_status_next = ffpa_pkg::ST_UNKNOWN;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_F_FIND_EV;
                end
            end

            S_F_FIND_EV:
            begin
                if (blk_rd_valid && blk_rd_start == hdr_reg)
                begin
                    need_next = blk_rd_len;
                    if (hdr_reg > top_reg || hdr_reg < base_reg)
                    begin
                        res_status_next = ffpa_pkg::ST_OUTSIDE;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_F_POS_RD;
                    end
                end
                else
                begin
                    slot_next  = slot_reg + ffpa_pkg::SLOT_W'(1);
                    state_next = S_F_FIND_RD;
                end
            end

            // Find the insertion point, keeping the lower neighbour
            S_F_POS_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_F_POS_EV;
                end
                else
                begin
                    has_p_next = 1'b0;
                    state_next = S_F_CHKQ;
                end
            end

            S_F_POS_EV:
            begin
                if (ext_rd_start < hdr_reg)
                begin
                    q_start_next = ext_rd_start;
                    q_len_next   = ext_rd_len;
                    idx_next     = idx_reg + CW'(1);
                    state_next   = S_F_POS_RD;
                end
                else
                begin
                    p_start_next = ext_rd_start;
                    p_len_next   = ext_rd_len;
                    has_p_next   = 1'b1;
                    state_next   = S_F_CHKQ;
                end
            end

            // Lower neighbour: overlap or touch
            S_F_CHKQ:
            begin
                alu_a = {1'b0, q_start_reg};
                alu_b = q_len_reg;
                alu_c = {1'b0, hdr_reg};
                if (idx_reg != '0 && alu_gt)
                begin
                    res_status_next = ffpa_pkg::ST_OVERLAP;
                    state_next      = S_FIN;
                end
                else
                begin
                    left_next  = (idx_reg != '0) && alu_eq;
                    state_next = S_F_CHKP;
                end
            end

            // Upper neighbour: overlap or touch
            S_F_CHKP:
            begin
                alu_a = {1'b0, hdr_reg};
                alu_b = need_reg;
                alu_c = {1'b0, p_start_reg};
                if (has_p_reg && alu_gt)
                begin
                    res_status_next = ffpa_pkg::ST_OVERLAP;
                    state_next      = S_FIN;
                end
                else
                begin
                    right_next = has_p_reg && alu_eq;
                    state_next = S_F_MERGE;
                end
            end

            S_F_MERGE:
            begin
                if (left_reg && right_reg)
                begin
                    alu_a      = q_len_reg;
                    alu_b      = need_reg;
                    acc_next   = alu_sum[LW-1:0];
                    state_next = S_F_SUM;
                end
                else if (left_reg)
                begin
                    alu_a        = q_len_reg;
                    alu_b        = need_reg;
                    ext_wr.en    = 1'b1;
                    ext_wr.addr  = idx_reg[AW-1:0] - AW'(1);
                    ext_wr.start = q_start_reg;
                    ext_wr.len   = alu_sum[LW-1:0];
                    state_next   = S_COMMIT;
                end
                else if (right_reg)
                begin
                    alu_a        = p_len_reg;
                    alu_b        = need_reg;
                    ext_wr.en    = 1'b1;
                    ext_wr.addr  = idx_reg[AW-1:0];
                    ext_wr.start = hdr_reg;
                    ext_wr.len   = alu_sum[LW-1:0];
                    state_next   = S_COMMIT;
                end
                else if (cnt_reg >= CW'(ffpa_pkg::EXT_DEPTH))
                begin
                    res_status_next = ffpa_pkg::ST_FULL;
                    state_next      = S_FIN;
                end
                else
                begin
                    ptr_next   = cnt_reg;
                    state_next = S_INS_RD;
                end
            end

            // Merge with both neighbours, then drop the upper one
            S_F_SUM:
            begin
                alu_a        = acc_reg;
                alu_b        = p_len_reg;
                ext_wr.en    = 1'b1;
                ext_wr.addr  = idx_reg[AW-1:0] - AW'(1);
                ext_wr.start = q_start_reg;
                ext_wr.len   = alu_sum[LW-1:0];
                ptr_next     = idx_reg + CW'(1);
                state_next   = S_DROP_RD;
            end

            // Open a gap for a new extent, top entry first
            S_INS_RD:
            begin
                if (ptr_reg > idx_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_WR:
            begin
                ext_wr.en    = 1'b1;
                ext_wr.addr  = ptr_reg[AW-1:0];
                ext_wr.start = ext_rd_start;
                ext_wr.len   = ext_rd_len;
                ptr_next     = ptr_m1;
                state_next   = S_INS_RD;
            end

            S_INS_PUT:
            begin
                ext_wr.en    = 1'b1;
                ext_wr.addr  = idx_reg[AW-1:0];
                ext_wr.start = hdr_reg;
                ext_wr.len   = need_reg;
                cnt_next     = cnt_reg + CW'(1);
                state_next   = S_COMMIT;
            end

            // Hold the result until the output register is free
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    address_next   = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            ptr_reg        <= '0;
            slot_reg       <= '0;
            has_p_reg      <= 1'b0;
            left_reg       <= 1'b0;
            right_reg      <= 1'b0;
            is_free_reg    <= 1'b0;
            res_status_reg <= ffpa_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            base_reg       <= '0;
            top_reg        <= 16'hFFFF;
            maxreq_reg     <= 16'd4096;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            ptr_reg        <= ptr_next;
            slot_reg       <= slot_next;
            has_p_reg      <= has_p_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            is_free_reg    <= is_free_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            base_reg       <= base_next;
            top_reg        <= top_next;
            maxreq_reg     <= maxreq_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hdr_reg      <= hdr_next;
        need_reg     <= need_next;
        kind_reg     <= kind_next;
        q_start_reg  <= q_start_next;
        q_len_reg    <= q_len_next;
        p_start_reg  <= p_start_next;
        p_len_reg    <= p_len_next;
        acc_reg      <= acc_next;
        res_addr_reg <= res_addr_next;
        status_reg   <= status_next;
        address_reg  <= address_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign address   = address_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ffpa_pkg::EXT_DEPTH))
        else $error("extent count beyond table depth");

    a_ext_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ext_wr.en |-> ({1'b0, ext_wr.addr} <= cnt_reg))
        else $error("extent write past the live entries");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside the final state");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && address_reg != '0) |-> (status_reg == ffpa_pkg::ST_OK))
        else $error("nonzero address with a failure status");
`endif

endmodule

`default_nettype wire
